// File: design/irpd_pkg.sv
// Shared types and constants for the IR pulse-distance decoder.
`default_nettype none
package irpd_pkg;

    localparam int MAX_BYTES  = 16;
    localparam int TIME_WIDTH = 16;
    localparam int RX_W       = $clog2(MAX_BYTES + 1);
    localparam int IDX_W      = 4;
    localparam int ADDR_W     = 6;
    localparam int DATA_W     = 64;
    localparam int REG_SEL_W  = 3;

    localparam logic [TIME_WIDTH-1:0] DUR_MAX = {TIME_WIDTH{1'b1}};

    // Register map (index = paddr / 8)
    localparam logic [REG_SEL_W-1:0] REG_CODE_LENGTH   = 3'd0;
    localparam logic [REG_SEL_W-1:0] REG_DATA_POSITION = 3'd1;
    localparam logic [REG_SEL_W-1:0] REG_EXPECTED_CODE = 3'd2;
    localparam logic [REG_SEL_W-1:0] REG_LEADER_MIN    = 3'd3;
    localparam logic [REG_SEL_W-1:0] REG_ONE_MIN       = 3'd4;
    localparam logic [REG_SEL_W-1:0] REG_STOP_MIN      = 3'd5;

    localparam logic [3:0]  RST_CODE_LENGTH   = 4'd0;
    localparam logic [4:0]  RST_DATA_POSITION = 5'd1;
    localparam logic [63:0] RST_EXPECTED_CODE = 64'd0;
    localparam logic [15:0] RST_LEADER_MIN    = 16'd3200;
    localparam logic [15:0] RST_ONE_MIN       = 16'd1000;
    localparam logic [15:0] RST_STOP_MIN      = 16'd10000;

    localparam logic       KIND_BYTE    = 1'b0;
    localparam logic       KIND_SUMMARY = 1'b1;
    localparam logic [8:0] NO_MATCH     = 9'h100;

    typedef struct packed {
        logic [3:0]  code_length;
        logic [4:0]  data_position;
        logic [63:0] expected_code;
        logic [15:0] leader_min;
        logic [15:0] one_min;
        logic [15:0] stop_min;
    } t_cfg;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] byte_index;
        logic [7:0]       byte_value;
        logic [4:0]       byte_count;
        logic             matched;
        logic [8:0]       data_value;
    } t_res;

    typedef struct packed {
        logic valid;
        t_res res;
    } t_push;

endpackage
`default_nettype wire

// File: design/irpd_if.sv
// Channel interfaces: line samples in, decoded results out.
`default_nettype none
interface irpd_ir_if;
    logic valid;
    logic ready;
    logic ir_level;

    modport source (output valid, output ir_level, input ready);
    modport sink   (input valid, input ir_level, output ready);
endinterface

interface irpd_res_if;
    import irpd_pkg::*;
    logic             valid;
    logic             ready;
    logic             kind;
    logic [IDX_W-1:0] byte_index;
    logic [7:0]       byte_value;
    logic [4:0]       byte_count;
    logic             matched;
    logic [8:0]       data_value;

    modport source (output valid, output kind, output byte_index, output byte_value,
                    output byte_count, output matched, output data_value, input ready);
    modport sink   (input valid, input kind, input byte_index, input byte_value,
                    input byte_count, input matched, input data_value, output ready);
endinterface
`default_nettype wire

// File: design/irpd_cfg_regs.sv
// APB configuration registers of the decoder.
`default_nettype none
module irpd_cfg_regs (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [irpd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [irpd_pkg::DATA_W-1:0] pwdata,
    output logic      [irpd_pkg::DATA_W-1:0] prdata,
    output logic                           pready,
    output irpd_pkg::t_cfg                 o_cfg
);
    import irpd_pkg::*;

    t_cfg                 r_cfg;
    logic [REG_SEL_W-1:0] sel;
    logic                 wr;

    assign pready = 1'b1;
    assign sel    = paddr[ADDR_W-1:ADDR_W-REG_SEL_W];
    assign wr     = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.code_length   <= RST_CODE_LENGTH;
            r_cfg.data_position <= RST_DATA_POSITION;
            r_cfg.expected_code <= RST_EXPECTED_CODE;
            r_cfg.leader_min    <= RST_LEADER_MIN;
            r_cfg.one_min       <= RST_ONE_MIN;
            r_cfg.stop_min      <= RST_STOP_MIN;
        end else if (wr) begin
            case (sel)
                REG_CODE_LENGTH:   r_cfg.code_length   <= pwdata[3:0];
                REG_DATA_POSITION: r_cfg.data_position <= pwdata[4:0];
                REG_EXPECTED_CODE: r_cfg.expected_code <= pwdata;
                REG_LEADER_MIN:    r_cfg.leader_min    <= pwdata[15:0];
                REG_ONE_MIN:       r_cfg.one_min       <= pwdata[15:0];
                REG_STOP_MIN:      r_cfg.stop_min      <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (sel)
            REG_CODE_LENGTH:   prdata = {60'd0, r_cfg.code_length};
            REG_DATA_POSITION: prdata = {59'd0, r_cfg.data_position};
            REG_EXPECTED_CODE: prdata = r_cfg.expected_code;
            REG_LEADER_MIN:    prdata = {48'd0, r_cfg.leader_min};
            REG_ONE_MIN:       prdata = {48'd0, r_cfg.one_min};
            REG_STOP_MIN:      prdata = {48'd0, r_cfg.stop_min};
            default:           prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: design/irpd_decoder.sv
// Input sample register and per-tick frame decoder.
`default_nettype none
module irpd_decoder (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire irpd_pkg::t_cfg i_cfg,
    input  wire logic           i_valid,
    input  wire logic           i_level,
    output logic                o_ready,
    input  wire logic           i_room,
    output irpd_pkg::t_push     o_push
);
    import irpd_pkg::*;

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_LEAD_LOW  = 3'd1;
    localparam logic [2:0] PH_LEAD_HIGH = 3'd2;
    localparam logic [2:0] PH_DATA_LOW  = 3'd3;
    localparam logic [2:0] PH_DATA_HIGH = 3'd4;

    logic                  r_in_valid, r_in_level;
    logic [2:0]            r_phase, n_phase;
    logic [TIME_WIDTH-1:0] r_dur, n_dur;
    logic [7:0]            r_shift, n_shift;
    logic [2:0]            r_bitpos, n_bitpos;
    logic [RX_W-1:0]       r_rx, n_rx;
    logic                  r_mismatch, n_mismatch;
    logic [7:0]            r_sel, n_sel;

    logic                  adv;
    logic [TIME_WIDTH-1:0] dur_inc;
    logic [7:0]            new_shift;
    logic                  gap_end;
    logic                  mat;
    t_res                  res;
    logic                  emit;

    function automatic logic [7:0] exp_byte(input logic [63:0] code,
                                            input logic [RX_W-1:0] i);
        logic [7:0] b;
        b = 8'd0;
        if (i < RX_W'(8))
            b = code[{i[2:0], 3'b000} +: 8];
        return b;
    endfunction

    assign adv     = r_in_valid && i_room;
    assign o_ready = !r_in_valid || adv;
    assign dur_inc = (r_dur != DUR_MAX) ? r_dur + 1'b1 : r_dur;
    assign new_shift = r_shift | (8'((r_dur >= i_cfg.one_min) ? 1 : 0) << r_bitpos);

    // frame summary: code positions not yet received compare as zero
    always_comb begin
        mat = (r_rx != '0) && !r_mismatch;
        for (int k = 0; k < 8; k++) begin
            if (RX_W'(k) >= r_rx && 4'(k) < i_cfg.code_length
                    && i_cfg.expected_code[8*k +: 8] != 8'd0)
                mat = 1'b0;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_dur      = r_dur;
        n_shift    = r_shift;
        n_bitpos   = r_bitpos;
        n_rx       = r_rx;
        n_mismatch = r_mismatch;
        n_sel      = r_sel;
        emit       = 1'b0;
        gap_end    = 1'b0;
        res        = '0;
        case (r_phase)
            PH_IDLE: begin
                if (!r_in_level) begin
                    n_dur   = TIME_WIDTH'(1);
                    n_phase = PH_LEAD_LOW;
                end
            end
            PH_LEAD_LOW: begin
                if (!r_in_level) begin
                    n_dur = dur_inc;
                end else if (r_dur >= i_cfg.leader_min) begin
                    n_shift    = '0;
                    n_bitpos   = '0;
                    n_rx       = '0;
                    n_mismatch = 1'b0;
                    n_sel      = '0;
                    n_phase    = PH_LEAD_HIGH;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_LEAD_HIGH: begin
                if (!r_in_level)
                    n_phase = PH_DATA_LOW;
            end
            PH_DATA_LOW: begin
                if (r_in_level) begin
                    n_dur   = TIME_WIDTH'(1);
                    n_phase = PH_DATA_HIGH;
                    gap_end = 1'b1;
                end
            end
            PH_DATA_HIGH: begin
                if (r_in_level) begin
                    n_dur   = dur_inc;
                    gap_end = 1'b1;
                end else begin
                    n_phase  = PH_DATA_LOW;
                    n_shift  = new_shift;
                    n_bitpos = r_bitpos + 1'b1;
                    if (r_bitpos == 3'd7) begin
                        n_shift = '0;
                        if (r_rx < RX_W'(MAX_BYTES)) begin
                            if (r_rx < RX_W'(i_cfg.code_length)
                                    && new_shift != exp_byte(i_cfg.expected_code, r_rx))
                                n_mismatch = 1'b1;
                            if (i_cfg.data_position != 5'd0
                                    && RX_W'(r_rx) == RX_W'(i_cfg.data_position - 5'd1))
                                n_sel = new_shift;
                            n_rx           = r_rx + 1'b1;
                            emit           = 1'b1;
                            res.kind       = KIND_BYTE;
                            res.byte_index = r_rx[IDX_W-1:0];
                            res.byte_value = new_shift;
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
        // a long enough high gap, or a saturated timer, closes the frame
        if (gap_end && (n_dur >= i_cfg.stop_min || n_dur == DUR_MAX)) begin
            emit           = 1'b1;
            res            = '0;
            res.kind       = KIND_SUMMARY;
            res.byte_count = 5'(r_rx);
            res.matched    = mat;
            res.data_value = mat ? {1'b0, r_sel} : NO_MATCH;
            n_phase        = PH_IDLE;
            n_dur          = '0;
        end
    end

    assign o_push.valid = adv && emit;
    assign o_push.res   = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_IDLE;
            r_dur      <= '0;
            r_shift    <= '0;
            r_bitpos   <= '0;
            r_rx       <= '0;
            r_mismatch <= 1'b0;
            r_sel      <= '0;
        end else begin
            if (o_ready)
                r_in_valid <= i_valid;
            if (adv) begin
                r_phase    <= n_phase;
                r_dur      <= n_dur;
                r_shift    <= n_shift;
                r_bitpos   <= n_bitpos;
                r_rx       <= n_rx;
                r_mismatch <= n_mismatch;
                r_sel      <= n_sel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid)
            r_in_level <= i_level;
    end

endmodule
`default_nettype wire

// File: design/irpd_res_queue.sv
// Two-entry result register with skid entry on the output side.
`default_nettype none
module irpd_res_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire irpd_pkg::t_push i_push,
    output logic                 o_room,
    output logic                 o_valid,
    output irpd_pkg::t_res       o_res,
    input  wire logic            i_ready
);
    import irpd_pkg::*;

    logic [1:0] r_cnt, n_cnt;
    t_res       r_q [2];
    t_res       n_q [2];
    logic       pop;
    logic [1:0] cnt_after;

    assign o_room    = (r_cnt < 2'd2);
    assign o_valid   = (r_cnt != 2'd0);
    assign o_res     = r_q[0];
    assign pop       = o_valid && i_ready;
    assign cnt_after = r_cnt - {1'b0, pop};

    always_comb begin
        n_q[0] = pop ? r_q[1] : r_q[0];
        n_q[1] = r_q[1];
        n_cnt  = cnt_after;
        if (i_push.valid) begin
            n_q[cnt_after[0]] = i_push.res;
            n_cnt             = cnt_after + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_cnt <= '0;
        else
            r_cnt <= n_cnt;
    end

    always_ff @(posedge i_clk) begin
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
    end

endmodule
`default_nettype wire

// File: design/ir_remote_pulse_decoder.sv
// Top level of the IR pulse-distance remote decoder.
// Takes one sample of the active-low receiver line per tick and accepts a sample every
// clock cycle; a sample's result (a completed byte or a frame-end summary) is offered at
// the output from the result queue. Each sample goes through an input register and the
// decode logic into a two-entry result queue, so one stalled result never stops the
// sample stream; the input stalls only once both queue entries are full.
// Thresholds and the expected code are set through the APB port (registers at 8-byte
// spacing) and should be changed only while no frame is being received.
`default_nettype none
module ir_remote_pulse_decoder (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    irpd_ir_if.sink                          i_ir,
    irpd_res_if.source                       o_res,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [irpd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [irpd_pkg::DATA_W-1:0] pwdata,
    output logic      [irpd_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);
    import irpd_pkg::*;

    t_cfg  cfg;
    t_push push;
    t_res  res;
    logic  room;
    logic  ready;
    logic  res_valid;

    irpd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    irpd_decoder u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_ir.valid),
        .i_level (i_ir.ir_level),
        .o_ready (ready),
        .i_room  (room),
        .o_push  (push)
    );

    irpd_res_queue u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (res_valid),
        .o_res   (res),
        .i_ready (o_res.ready)
    );

    assign i_ir.ready       = ready;
    assign o_res.valid      = res_valid;
    assign o_res.kind       = res.kind;
    assign o_res.byte_index = res.byte_index;
    assign o_res.byte_value = res.byte_value;
    assign o_res.byte_count = res.byte_count;
    assign o_res.matched    = res.matched;
    assign o_res.data_value = res.data_value;

endmodule
`default_nettype wire

// File: design/irpd_checker.sv
// Port-level assertions for the decoder, bound to the top level.
`default_nettype none
module irpd_port_checks (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic [8:0] res_data_value,
    input wire logic [4:0] res_byte_count
);
    logic in_acc;
    assign in_acc = in_valid && in_ready;

    // no result leaves the block straight after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !res_valid)
        else $error("result valid after reset");

    // a result with an empty queue comes from a sample that went through the input register and then the queue
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(res_valid) |-> $past(in_acc, 2))
        else $error("result without a preceding sample transaction");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_ready |=> $stable(res_data_value) && $stable(res_byte_count))
        else $error("result payload changed while stalled");

endmodule

bind ir_remote_pulse_decoder irpd_port_checks u_irpd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .in_valid       (i_ir.valid),
    .in_ready       (i_ir.ready),
    .res_valid      (o_res.valid),
    .res_ready      (o_res.ready),
    .res_data_value (o_res.data_value),
    .res_byte_count (o_res.byte_count)
);
`default_nettype wire
